// ===== rtl/ecpsm_pkg.sv =====
// shared types, register indexes and state codes for the point multiplier
package ecpsm_pkg;

  // request and result payloads
  typedef struct packed {
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [15:0] scalar;
  } ec_in_t;

  typedef struct packed {
    logic [15:0] result_x;
    logic [15:0] result_y;
    logic        result_at_infinity;
  } ec_out_t;

  // configuration register map
  localparam int          CFG_IDX_W       = 8;
  localparam logic [7:0]  CFG_CURVE_A     = 8'd0;
  localparam logic [7:0]  CFG_MODULUS_P   = 8'd1;
  localparam logic [15:0] CURVE_A_RESET   = 16'd1;
  localparam logic [15:0] MODULUS_P_RESET = 16'd19;

  // shared arithmetic unit operations
  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic    go;
    alu_op_t op;
  } alu_ctl_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_X,
    ST_RED_Y,
    ST_LOOP,
    ST_STEP,
    ST_PA_CHK,
    ST_DB_SQ,
    ST_DB_3,
    ST_DB_NUM,
    ST_DB_DEN,
    ST_AD_NUM,
    ST_AD_DEN,
    ST_INV_CHK,
    ST_INV_DIV,
    ST_INV_MUL,
    ST_INV_SUB,
    ST_SLOPE,
    ST_X_SQ,
    ST_X_S1,
    ST_X_S2,
    ST_Y_S1,
    ST_Y_MUL,
    ST_Y_S2,
    ST_PA_END,
    ST_FIN
  } seq_state_t;

endpackage

// ===== rtl/ecpsm_alu.sv =====
// shared modular arithmetic unit: bit-serial mul mod p, division, add and sub mod p
module ecpsm_alu
  import ecpsm_pkg::*;
#(
  parameter int FW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  alu_ctl_t      ctl,
  input  logic [FW-1:0] opa,
  input  logic [FW-1:0] opb,
  input  logic [FW-1:0] p,
  output logic          done,
  output logic [FW-1:0] res,
  output logic [FW-1:0] rem
);

  localparam int CW = $clog2(FW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  alu_op_t       op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [FW-1:0] a_r, a_nxt;
  logic [FW-1:0] b_r, b_nxt;
  logic [FW-1:0] acc_r, acc_nxt;

  logic [FW:0]   shl, red, sum, sum_red, dif, dif_red;
  logic [FW-1:0] mod_sel, addend, sa, sb;
  logic          qbit;

  // one step of the selected operation
  always_comb begin
    shl     = {acc_r, (op_r == ALU_DIV) ? b_r[FW-1] : 1'b0};
    mod_sel = (op_r == ALU_DIV) ? a_r : p;
    qbit    = (shl >= {1'b0, mod_sel});
    red     = qbit ? (shl - {1'b0, mod_sel}) : shl;
    addend  = (b_r[FW-1]) ? a_r : '0;
    sa      = (op_r == ALU_ADD) ? a_r : red[FW-1:0];
    sb      = (op_r == ALU_ADD) ? b_r : addend;
    sum     = {1'b0, sa} + {1'b0, sb};
    sum_red = (sum >= {1'b0, p}) ? (sum - {1'b0, p}) : sum;
    dif     = {1'b0, a_r} - {1'b0, b_r};
    dif_red = dif[FW] ? (dif + {1'b0, p}) : dif;
  end

  // operand load and step control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (ctl.go) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      a_nxt    = opa;
      b_nxt    = opb;
      acc_nxt  = '0;
      cnt_nxt  = ((ctl.op == ALU_MUL) || (ctl.op == ALU_DIV)) ? CW'(FW) : CW'(1);
    end else if (busy_r) begin
      case (op_r)
        ALU_MUL: begin
          acc_nxt = sum_red[FW-1:0];
          b_nxt   = {b_r[FW-2:0], 1'b0};
        end
        ALU_DIV: begin
          acc_nxt = red[FW-1:0];
          b_nxt   = {b_r[FW-2:0], qbit};
        end
        ALU_ADD: begin
          acc_nxt = sum_red[FW-1:0];
        end
        ALU_SUB: begin
          acc_nxt = dif_red[FW-1:0];
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= ALU_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign res  = (op_r == ALU_DIV) ? b_r : acc_r;
  assign rem  = acc_r;

endmodule

// ===== rtl/ecpsm_seq.sv =====
// sequencer for double-and-add with slope formulas and euclid inverse
module ecpsm_seq
  import ecpsm_pkg::*;
#(
  parameter int FW = 16,
  parameter int SB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [FW-1:0] x_in,
  input  logic [FW-1:0] y_in,
  input  logic [SB-1:0] n_in,
  input  logic [FW-1:0] a_cfg,
  input  logic [FW-1:0] p_cfg,
  input  logic          out_free,
  output logic          idle,
  output logic          done,
  output logic [FW-1:0] res_x,
  output logic [FW-1:0] res_y,
  output logic          res_inf,
  output alu_ctl_t      alu_ctl,
  output logic [FW-1:0] alu_a,
  output logic [FW-1:0] alu_b,
  input  logic          alu_done,
  input  logic [FW-1:0] alu_res,
  input  logic [FW-1:0] alu_rem
);

  localparam logic [FW-1:0] ONE_F   = FW'(1);
  localparam logic [FW-1:0] TWO_F   = FW'(2);
  localparam logic [FW-1:0] THREE_F = FW'(3);

  seq_state_t    state_r, state_nxt;
  logic          iss_r, iss_nxt;
  logic          pa_dbl_r, pa_dbl_nxt;
  logic [SB-1:0] n_r, n_nxt;
  logic [FW-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic          ainf_r, ainf_nxt;
  logic [FW-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic          dinf_r, dinf_nxt;
  logic [FW-1:0] am_r, am_nxt;
  logic [FW-1:0] t_r, t_nxt, num_r, num_nxt, s_r, s_nxt, ox_r, ox_nxt;
  logic [FW-1:0] r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic [FW-1:0] q_r, q_nxt, rm_r, rm_nxt;

  logic          use_alu;
  alu_op_t       op;
  logic [FW-1:0] lx, ly, c3, n_sh;
  logic          linf;
  logic          wr_en, wr_inf;
  logic [FW-1:0] wr_x, wr_y;

  // left operand of the point operation is the accumulator or the doubled point
  always_comb begin
    lx   = pa_dbl_r ? dx_r : ax_r;
    ly   = pa_dbl_r ? dy_r : ay_r;
    linf = pa_dbl_r ? dinf_r : ainf_r;
    c3   = (p_cfg == THREE_F) ? '0 : THREE_F;
    n_sh = '0;
  end

  // next state and datapath control
  always_comb begin
    state_nxt  = state_r;
    iss_nxt    = iss_r;
    pa_dbl_nxt = pa_dbl_r;
    n_nxt      = n_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    ainf_nxt   = ainf_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    dinf_nxt   = dinf_r;
    am_nxt     = am_r;
    t_nxt      = t_r;
    num_nxt    = num_r;
    s_nxt      = s_r;
    ox_nxt     = ox_r;
    r0_nxt     = r0_r;
    r1_nxt     = r1_r;
    t0_nxt     = t0_r;
    t1_nxt     = t1_r;
    q_nxt      = q_r;
    rm_nxt     = rm_r;
    use_alu    = 1'b0;
    op         = ALU_MUL;
    alu_a      = '0;
    alu_b      = '0;
    wr_en      = 1'b0;
    wr_inf     = 1'b0;
    wr_x       = '0;
    wr_y       = '0;
    done       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          dx_nxt   = x_in;
          dy_nxt   = y_in;
          n_nxt    = n_in;
          ax_nxt   = '0;
          ay_nxt   = '0;
          ainf_nxt = 1'b1;
          state_nxt = (p_cfg < THREE_F) ? ST_FIN : ST_RED_A;
        end
      end
      // reduce a and the base point modulo p
      ST_RED_A: begin
        use_alu = 1'b1; op = ALU_MUL; alu_a = ONE_F; alu_b = a_cfg;
        if (alu_done) begin
          am_nxt    = alu_res;
          state_nxt = ST_RED_X;
        end
      end
      ST_RED_X: begin
        use_alu = 1'b1; op = ALU_MUL; alu_a = ONE_F; alu_b = dx_r;
        if (alu_done) begin
          dx_nxt    = alu_res;
          state_nxt = ST_RED_Y;
        end
      end
      ST_RED_Y: begin
        use_alu = 1'b1; op = ALU_MUL; alu_a = ONE_F; alu_b = dy_r;
        if (alu_done) begin
          dy_nxt    = alu_res;
          dinf_nxt  = (dx_r == '0) && (alu_res == '0);
          state_nxt = ST_LOOP;
        end
      end
      // scalar bit scan, low bit first
      ST_LOOP: begin
        if (n_r == '0) begin
          state_nxt = ST_FIN;
        end else if (n_r[0]) begin
          pa_dbl_nxt = 1'b0;
          state_nxt  = ST_PA_CHK;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        n_nxt = n_r >> 1;
        if ((n_r >> 1) != '0) begin
          pa_dbl_nxt = 1'b1;
          state_nxt  = ST_PA_CHK;
        end else begin
          state_nxt = ST_LOOP;
        end
      end
      // special cases of the point operation
      ST_PA_CHK: begin
        state_nxt = ST_PA_END;
        if (linf) begin
          wr_en = 1'b1; wr_x = dx_r; wr_y = dy_r; wr_inf = dinf_r;
        end else if (dinf_r) begin
          wr_en = 1'b1; wr_x = lx; wr_y = ly; wr_inf = 1'b0;
        end else if ((lx == dx_r) && ((ly != dy_r) || (ly == '0))) begin
          wr_en = 1'b1; wr_inf = 1'b1;
        end else if (lx == dx_r) begin
          state_nxt = ST_DB_SQ;
        end else begin
          state_nxt = ST_AD_NUM;
        end
      end
      // doubling slope parts: 3 x^2 + a over 2 y
      ST_DB_SQ: begin
        use_alu = 1'b1; op = ALU_MUL; alu_a = lx; alu_b = lx;
        if (alu_done) begin
          t_nxt = alu_res; state_nxt = ST_DB_3;
        end
      end
      ST_DB_3: begin
        use_alu = 1'b1; op = ALU_MUL; alu_a = c3; alu_b = t_r;
        if (alu_done) begin
          t_nxt = alu_res; state_nxt = ST_DB_NUM;
        end
      end
      ST_DB_NUM: begin
        use_alu = 1'b1; op = ALU_ADD; alu_a = t_r; alu_b = am_r;
        if (alu_done) begin
          num_nxt = alu_res; state_nxt = ST_DB_DEN;
        end
      end
      ST_DB_DEN: begin
        use_alu = 1'b1; op = ALU_MUL; alu_a = TWO_F; alu_b = ly;
        if (alu_done) begin
          r0_nxt = p_cfg; r1_nxt = alu_res; t0_nxt = '0; t1_nxt = ONE_F;
          state_nxt = ST_INV_CHK;
        end
      end
      // addition slope parts: y2 - y1 over x2 - x1
      ST_AD_NUM: begin
        use_alu = 1'b1; op = ALU_SUB; alu_a = dy_r; alu_b = ly;
        if (alu_done) begin
          num_nxt = alu_res; state_nxt = ST_AD_DEN;
        end
      end
      ST_AD_DEN: begin
        use_alu = 1'b1; op = ALU_SUB; alu_a = dx_r; alu_b = lx;
        if (alu_done) begin
          r0_nxt = p_cfg; r1_nxt = alu_res; t0_nxt = '0; t1_nxt = ONE_F;
          state_nxt = ST_INV_CHK;
        end
      end
      // extended euclid with coefficients kept as residues
      ST_INV_CHK: begin
        if (r1_r == '0) begin
          t_nxt     = (r0_r == ONE_F) ? t0_r : '0;
          state_nxt = ST_SLOPE;
        end else begin
          state_nxt = ST_INV_DIV;
        end
      end
      ST_INV_DIV: begin
        use_alu = 1'b1; op = ALU_DIV; alu_a = r1_r; alu_b = r0_r;
        if (alu_done) begin
          q_nxt = alu_res; rm_nxt = alu_rem; state_nxt = ST_INV_MUL;
        end
      end
      ST_INV_MUL: begin
        use_alu = 1'b1; op = ALU_MUL; alu_a = t1_r; alu_b = q_r;
        if (alu_done) begin
          q_nxt = alu_res; state_nxt = ST_INV_SUB;
        end
      end
      ST_INV_SUB: begin
        use_alu = 1'b1; op = ALU_SUB; alu_a = t0_r; alu_b = q_r;
        if (alu_done) begin
          t0_nxt = t1_r; t1_nxt = alu_res;
          r0_nxt = r1_r; r1_nxt = rm_r;
          state_nxt = ST_INV_CHK;
        end
      end
      // slope and new coordinates
      ST_SLOPE: begin
        use_alu = 1'b1; op = ALU_MUL; alu_a = num_r; alu_b = t_r;
        if (alu_done) begin
          s_nxt = alu_res; state_nxt = ST_X_SQ;
        end
      end
      ST_X_SQ: begin
        use_alu = 1'b1; op = ALU_MUL; alu_a = s_r; alu_b = s_r;
        if (alu_done) begin
          t_nxt = alu_res; state_nxt = ST_X_S1;
        end
      end
      ST_X_S1: begin
        use_alu = 1'b1; op = ALU_SUB; alu_a = t_r; alu_b = lx;
        if (alu_done) begin
          t_nxt = alu_res; state_nxt = ST_X_S2;
        end
      end
      ST_X_S2: begin
        use_alu = 1'b1; op = ALU_SUB; alu_a = t_r; alu_b = dx_r;
        if (alu_done) begin
          ox_nxt = alu_res; state_nxt = ST_Y_S1;
        end
      end
      ST_Y_S1: begin
        use_alu = 1'b1; op = ALU_SUB; alu_a = lx; alu_b = ox_r;
        if (alu_done) begin
          t_nxt = alu_res; state_nxt = ST_Y_MUL;
        end
      end
      ST_Y_MUL: begin
        use_alu = 1'b1; op = ALU_MUL; alu_a = s_r; alu_b = t_r;
        if (alu_done) begin
          t_nxt = alu_res; state_nxt = ST_Y_S2;
        end
      end
      ST_Y_S2: begin
        use_alu = 1'b1; op = ALU_SUB; alu_a = t_r; alu_b = ly;
        if (alu_done) begin
          wr_en = 1'b1; wr_x = ox_r; wr_y = alu_res; wr_inf = 1'b0;
          state_nxt = ST_PA_END;
        end
      end
      ST_PA_END: begin
        state_nxt = pa_dbl_r ? ST_LOOP : ST_STEP;
      end
      // hand the product to the output register
      ST_FIN: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // write back the point operation result
    if (wr_en) begin
      if (pa_dbl_r) begin
        dx_nxt = wr_x; dy_nxt = wr_y; dinf_nxt = wr_inf;
      end else begin
        ax_nxt = wr_x; ay_nxt = wr_y; ainf_nxt = wr_inf;
      end
    end

    // one request per arithmetic state
    alu_ctl.go = use_alu && !iss_r;
    alu_ctl.op = op;
    if (alu_ctl.go) begin
      iss_nxt = 1'b1;
    end else if (alu_done) begin
      iss_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      iss_r    <= 1'b0;
      pa_dbl_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      iss_r    <= iss_nxt;
      pa_dbl_r <= pa_dbl_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    ainf_r <= ainf_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    dinf_r <= dinf_nxt;
    am_r   <= am_nxt;
    t_r    <= t_nxt;
    num_r  <= num_nxt;
    s_r    <= s_nxt;
    ox_r   <= ox_nxt;
    r0_r   <= r0_nxt;
    r1_r   <= r1_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    q_r    <= q_nxt;
    rm_r   <= rm_nxt;
  end

  assign idle    = (state_r == ST_IDLE);
  assign res_inf = ainf_r;
  assign res_x   = ainf_r ? n_sh : ax_r;
  assign res_y   = ainf_r ? n_sh : ay_r;

endmodule

// ===== rtl/ec_point_scalar_multiply_top.sv =====
// top level: config registers, request and result channels, sequencer and arithmetic unit
// work: 3 reducing muls on the shared unit, then a doubling is 6 muls and 5 add/sub, an addition
//   3 muls and 6 subs, each with an inverse of k euclid rounds (k up to about 1.44 * FIELD_BITS)
//   at one div, mul and sub each; up to 2 * SCALAR_BITS - 1 point ops
// throughput: one request at a time, next taken once the result sits in the output register;
// reset: synchronous active low; curve_a returns to 1, modulus_p to 19, output empty
module ec_point_scalar_multiply_top
  import ecpsm_pkg::*;
#(
  parameter int FIELD_BITS  = 16,
  parameter int SCALAR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ec_in_t               in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ec_out_t              out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int FW = FIELD_BITS;
  localparam int SB = SCALAR_BITS;

  logic [15:0]    curve_a_r, curve_a_nxt, modulus_p_r, modulus_p_nxt;
  logic           out_valid_r, out_valid_nxt;
  ec_out_t        out_data_r, out_data_nxt;

  logic [FW+15:0] x_ext, y_ext, a_ext, p_ext, rx_ext, ry_ext;
  logic [SB+15:0] n_ext;
  logic           seq_idle, seq_done, res_inf, alu_done;
  logic [FW-1:0]  res_x, res_y, alu_a, alu_b, alu_res, alu_rem;
  alu_ctl_t       alu_ctl;
  logic           start;

  // fit port fields to the field width
  always_comb begin
    x_ext  = {{FW{1'b0}}, in_data.point_x};
    y_ext  = {{FW{1'b0}}, in_data.point_y};
    a_ext  = {{FW{1'b0}}, curve_a_r};
    p_ext  = {{FW{1'b0}}, modulus_p_r};
    n_ext  = {{SB{1'b0}}, in_data.scalar};
    rx_ext = {16'b0, res_x};
    ry_ext = {16'b0, res_y};
  end

  assign in_ready  = seq_idle;
  assign start     = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_comb begin
    curve_a_nxt   = curve_a_r;
    modulus_p_nxt = modulus_p_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CURVE_A) begin
        curve_a_nxt = cfg_data;
      end else if (cfg_index == CFG_MODULUS_P) begin
        modulus_p_nxt = cfg_data;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (seq_done) begin
      out_valid_nxt                   = 1'b1;
      out_data_nxt.result_x           = rx_ext[15:0];
      out_data_nxt.result_y           = ry_ext[15:0];
      out_data_nxt.result_at_infinity = res_inf;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_a_r   <= CURVE_A_RESET;
      modulus_p_r <= MODULUS_P_RESET;
      out_valid_r <= 1'b0;
    end else begin
      curve_a_r   <= curve_a_nxt;
      modulus_p_r <= modulus_p_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer
  ecpsm_seq #(
    .FW (FW),
    .SB (SB)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .x_in     (x_ext[FW-1:0]),
    .y_in     (y_ext[FW-1:0]),
    .n_in     (n_ext[SB-1:0]),
    .a_cfg    (a_ext[FW-1:0]),
    .p_cfg    (p_ext[FW-1:0]),
    .out_free (!out_valid_r || out_ready),
    .idle     (seq_idle),
    .done     (seq_done),
    .res_x    (res_x),
    .res_y    (res_y),
    .res_inf  (res_inf),
    .alu_ctl  (alu_ctl),
    .alu_a    (alu_a),
    .alu_b    (alu_b),
    .alu_done (alu_done),
    .alu_res  (alu_res),
    .alu_rem  (alu_rem)
  );

  // shared arithmetic unit
  ecpsm_alu #(
    .FW (FW)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .opa   (alu_a),
    .opb   (alu_b),
    .p     (p_ext[FW-1:0]),
    .done  (alu_done),
    .res   (alu_res),
    .rem   (alu_rem)
  );

  // an accepted request blocks the input until its result is handed over
  assert property (@(posedge clk) disable iff (!rst_n) start |=> !in_ready)
    else $error("input ready right after a request was taken");

  // a result at infinity carries zero coordinates
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_at_infinity |->
      (out_data.result_x == 16'd0) && (out_data.result_y == 16'd0))
    else $error("infinity result with nonzero coordinates");

  // a new result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    seq_done |-> (!out_valid_r || out_ready))
    else $error("result written over a pending one");

  // the output is empty right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== tb/sv/ec_point_scalar_multiply_top_tb.sv =====
// testbench for the elliptic-curve point multiplier: directed table, random points, scoreboard
`timescale 1ns / 100ps

module ec_point_scalar_multiply_top_tb;
  import ecpsm_pkg::*;

  localparam int  RANDOM_ITEMS = 300;
  localparam int  CYCLE_LIMIT  = 40000000;
  localparam int  DRAIN_CYCLES = 3000;

  // directed row: request, optional known answer
  typedef struct {
    ec_in_t  req;
    logic    known;
    ec_out_t ans;
  } dir_row_t;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  ec_in_t  in_data;
  logic    out_valid;
  logic    out_ready;
  ec_out_t out_data;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  // predictor copy of the curve registers
  logic [15:0] curve_a_q;
  logic [15:0] modulus_q;

  ec_out_t     product_q[$];
  int          errors;
  int          n_sent;
  int          n_recv;
  int          n_inf;
  longint      cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  dir_row_t    dir_rows[$];

  ec_point_scalar_multiply_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // modular helpers for the predictor
  function automatic longint unsigned mod_mul(longint unsigned u, longint unsigned v,
                                              longint unsigned p);
    return (u * v) % p;
  endfunction

  function automatic longint unsigned mod_sub(longint unsigned u, longint unsigned v,
                                              longint unsigned p);
    return (u >= v) ? u - v : u + p - v;
  endfunction

  function automatic longint unsigned mod_add(longint unsigned u, longint unsigned v,
                                              longint unsigned p);
    longint unsigned s;
    s = u + v;
    return (s >= p) ? s - p : s;
  endfunction

  // extended euclid, zero when not invertible
  function automatic longint unsigned mod_inv(longint unsigned v, longint unsigned p);
    longint r0, r1, t0, t1, q, tr, tt;
    r0 = p; r1 = v % p; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tr = r0 - q * r1; tt = t0 - q * t1;
      r0 = r1; r1 = tr; t0 = t1; t1 = tt;
    end
    if (r0 != 1) return 0;
    if (t0 < 0) t0 += p;
    return t0;
  endfunction

  // affine point sum with infinity flag
  function automatic void point_sum(input longint unsigned lx, ly, input bit linf,
                                    input longint unsigned rx, ry, input bit rinf,
                                    input longint unsigned a, p,
                                    output longint unsigned ox, oy, output bit oinf);
    longint unsigned s, num;
    if (linf) begin
      ox = rx; oy = ry; oinf = rinf;
    end else if (rinf) begin
      ox = lx; oy = ly; oinf = linf;
    end else if (lx == rx && (ly != ry || ly == 0)) begin
      ox = 0; oy = 0; oinf = 1;
    end else begin
      if (lx == rx) begin
        num = mod_add(mod_mul(3 % p, mod_mul(lx, lx, p), p), a, p);
        s = mod_mul(num, mod_inv(mod_mul(2 % p, ly, p), p), p);
      end else begin
        s = mod_mul(mod_sub(ry, ly, p), mod_inv(mod_sub(rx, lx, p), p), p);
      end
      ox = mod_sub(mod_sub(mod_mul(s, s, p), lx, p), rx, p);
      oy = mod_sub(mod_mul(s, mod_sub(lx, ox, p), p), ly, p);
      oinf = 0;
    end
  endfunction

  // double-and-add product of one request
  function automatic ec_out_t scalar_product(ec_in_t req);
    longint unsigned p, a, n, ax, ay, dx, dy, tx, ty;
    bit ainf, dinf, tinf;
    ec_out_t r;
    p = modulus_q; n = req.scalar;
    ax = 0; ay = 0; ainf = 1;
    if (p >= 3) begin
      a = curve_a_q % p;
      dx = req.point_x % p; dy = req.point_y % p;
      dinf = (dx == 0 && dy == 0);
      while (n != 0) begin
        if (n[0]) begin
          point_sum(ax, ay, ainf, dx, dy, dinf, a, p, tx, ty, tinf);
          ax = tx; ay = ty; ainf = tinf;
        end
        n >>= 1;
        if (n != 0) begin
          point_sum(dx, dy, dinf, dx, dy, dinf, a, p, tx, ty, tinf);
          dx = tx; dy = ty; dinf = tinf;
        end
      end
    end
    r.result_x = ainf ? 16'd0 : ax[15:0];
    r.result_y = ainf ? 16'd0 : ay[15:0];
    r.result_at_infinity = ainf;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    ec_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (product_q.size() == 0) begin
        $error("result with no request pending: %h", out_data);
        errors++;
      end else begin
        exp_r = product_q.pop_front();
        n_recv++;
        if (exp_r.result_at_infinity) n_inf++;
        if (out_data.result_x !== exp_r.result_x) begin
          $error("result_x expected %0d actual %0d", exp_r.result_x, out_data.result_x);
          errors++;
        end
        if (out_data.result_y !== exp_r.result_y) begin
          $error("result_y expected %0d actual %0d", exp_r.result_y, out_data.result_y);
          errors++;
        end
        if (out_data.result_at_infinity !== exp_r.result_at_infinity) begin
          $error("result_at_infinity expected %0d actual %0d",
                 exp_r.result_at_infinity, out_data.result_at_infinity);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // register write while idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CURVE_A) curve_a_q = val;
    else if (idx == CFG_MODULUS_P) modulus_q = val;
    @(posedge clk);
  endtask

  // wait for all results plus a quiet spell
  task automatic drain;
    while (product_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // send one request, with random gaps before it
  task automatic send_req(input ec_in_t req, input logic known, input ec_out_t ans);
    ec_out_t pred;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    pred = scalar_product(req);
    if (known && pred !== ans) begin
      $error("table answer disagrees with predictor for %h", req);
      errors++;
    end
    product_q.push_back(known ? ans : pred);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    n_sent++;
    @(posedge clk);
  endtask

  function automatic dir_row_t row(logic [15:0] x, y, k, logic known,
                                   logic [15:0] rx, ry, logic inf);
    dir_row_t r;
    r.req = '{point_x: x, point_y: y, scalar: k};
    r.known = known;
    r.ans = '{result_x: rx, result_y: ry, result_at_infinity: inf};
    return r;
  endfunction

  // point on the current curve with a random x, or a random pair
  function automatic ec_in_t rand_req(int kmax);
    ec_in_t r;
    int unsigned p, a, x, y, rhs, tries;
    p = modulus_q; a = curve_a_q % p;
    r.scalar = 16'($urandom_range(kmax));
    r.point_x = 16'($urandom_range(p - 1));
    r.point_y = 16'($urandom_range(p - 1));
    if ($urandom_range(9) < 8 && p <= 2000) begin
      for (tries = 0; tries < 40; tries++) begin
        x = $urandom_range(p - 1);
        rhs = (((x * x) % p) * x + a * x) % p;
        for (y = 0; y < p; y++) begin
          if ((y * y) % p == rhs) begin
            r.point_x = 16'(x);
            r.point_y = 16'(($urandom_range(1) && y != 0) ? p - y : y);
            return r;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic random_phase(int count, int kmax);
    ec_in_t r;
    for (int i = 0; i < count; i++) begin
      r = rand_req(kmax);
      if ($urandom_range(19) == 0) r = 48'({$urandom, $urandom});
      send_req(r, 1'b0, '0);
    end
  endtask

  initial begin
    errors = 0; n_sent = 0; n_recv = 0; n_inf = 0; cycles = 0;
    send_idle_pct = 21; recv_idle_pct = 49;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    curve_a_q = CURVE_A_RESET; modulus_q = MODULUS_P_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table on the reset curve y^2 = x^3 + x + b mod 19
    dir_rows.push_back(row(16'd0, 16'd0, 16'd5, 1'b1, 16'd0, 16'd0, 1'b1));
    dir_rows.push_back(row(16'd3, 16'd4, 16'd0, 1'b1, 16'd0, 16'd0, 1'b1));
    dir_rows.push_back(row(16'd3, 16'd4, 16'd1, 1'b1, 16'd3, 16'd4, 1'b0));
    dir_rows.push_back(row(16'd22, 16'd23, 16'd1, 1'b1, 16'd3, 16'd4, 1'b0));
    dir_rows.push_back(row(16'd19, 16'd38, 16'd7, 1'b1, 16'd0, 16'd0, 1'b1));
    dir_rows.push_back(row(16'd5, 16'd0, 16'd2, 1'b1, 16'd0, 16'd0, 1'b1));
    dir_rows.push_back(row(16'd3, 16'd4, 16'd2, 1'b0, '0, '0, 1'b0));
    dir_rows.push_back(row(16'd3, 16'd4, 16'd3, 1'b0, '0, '0, 1'b0));
    dir_rows.push_back(row(16'd3, 16'd4, 16'hFFFF, 1'b0, '0, '0, 1'b0));
    dir_rows.push_back(row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0, '0, 1'b0));
    dir_rows.push_back(row(16'hAAAA, 16'h5555, 16'h8000, 1'b0, '0, '0, 1'b0));
    dir_rows.push_back(row(16'h5555, 16'hAAAA, 16'h7FFF, 1'b0, '0, '0, 1'b0));
    dir_rows.push_back(row(16'd0, 16'd1, 16'd6, 1'b0, '0, '0, 1'b0));
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].ans);
    drain();

    // extremes of the registers: degenerate and largest moduli
    write_reg(CFG_MODULUS_P, 16'd2);
    write_reg(CFG_CURVE_A, 16'hFFFF);
    send_req('{point_x: 16'd1, point_y: 16'd1, scalar: 16'd3}, 1'b1,
             '{16'd0, 16'd0, 1'b1});
    drain();
    write_reg(CFG_MODULUS_P, 16'hFFF1);
    send_req('{point_x: 16'hFFFF, point_y: 16'h1234, scalar: 16'hFFFF}, 1'b0, '0);
    send_req('{point_x: 16'h0001, point_y: 16'hFFF0, scalar: 16'h00FF}, 1'b0, '0);
    drain();
    write_reg(CFG_MODULUS_P, 16'd15);
    write_reg(CFG_CURVE_A, 16'd0);
    send_req('{point_x: 16'd3, point_y: 16'd5, scalar: 16'd9}, 1'b0, '0);
    send_req('{point_x: 16'd6, point_y: 16'd10, scalar: 16'd13}, 1'b0, '0);
    drain();

    // random phases across curves and idle mixes
    write_reg(CFG_MODULUS_P, 16'd97);
    write_reg(CFG_CURVE_A, 16'd2);
    random_phase(100, 1000);
    drain();
    send_idle_pct = 49; recv_idle_pct = 21;
    write_reg(CFG_MODULUS_P, 16'd1009);
    write_reg(CFG_CURVE_A, 16'd1008);
    random_phase(100, 65535);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(CFG_MODULUS_P, 16'd65521);
    write_reg(CFG_CURVE_A, 16'd7);
    random_phase(20, 65535);
    drain();
    write_reg(CFG_MODULUS_P, 16'd13);
    write_reg(CFG_CURVE_A, 16'd1);
    random_phase(80, 65535);

    drain();
    $display("covered %0d requests, %0d results (%0d at infinity), moduli 2 to 65521",
             n_sent, n_recv, n_inf);
    if (errors == 0 && product_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ecpsm_pkg.sv
rtl/ecpsm_alu.sv
rtl/ecpsm_seq.sv
rtl/ec_point_scalar_multiply_top.sv
tb/sv/ec_point_scalar_multiply_top_tb.sv
